### hw/rtl/bnfa_pkg.sv
package bnfa_pkg;

    localparam int MAX_BLOCKS    = 1024;
    localparam int BITS_PER_BYTE = 8;
    localparam int MAP_BYTES     = MAX_BLOCKS / BITS_PER_BYTE;

    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int BYTE_IDX_W = $clog2(MAP_BYTES);
    localparam int BIT_W      = $clog2(BITS_PER_BYTE);
    localparam int COUNT_W    = 11;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

    // One write into the map store.
    typedef struct packed {
        logic                     en;
        logic [BYTE_IDX_W-1:0]    addr;
        logic [BITS_PER_BYTE-1:0] data;
    } map_wr_t;

    // Outcome of examining one map byte during an allocation scan.
    typedef struct packed {
        logic                     found;
        logic [BIT_W-1:0]         bit_pos;
        logic [BITS_PER_BYTE-1:0] new_byte;
    } scan_hit_t;

endpackage

### hw/rtl/bnfa_ram.sv
module bnfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/bnfa_map.sv
module bnfa_map (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bnfa_pkg::map_wr_t                    wr,
    input  logic [bnfa_pkg::BYTE_IDX_W-1:0]      rd_addr,
    output logic [bnfa_pkg::BITS_PER_BYTE-1:0]   rd_data
);
    import bnfa_pkg::*;

    // One valid bit per byte: a byte never written since reset reads as all free.
    logic [MAP_BYTES-1:0]     valid_reg;
    logic                     rd_valid_reg;
    logic [BITS_PER_BYTE-1:0] ram_q;

    bnfa_ram #(
        .WIDTH (BITS_PER_BYTE),
        .DEPTH (MAP_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = ram_q & {BITS_PER_BYTE{rd_valid_reg}};

endmodule

### hw/rtl/bnfa_byte_scan.sv
module bnfa_byte_scan (
    input  logic [bnfa_pkg::BITS_PER_BYTE-1:0] data,
    input  logic                               is_last,
    input  logic [bnfa_pkg::BIT_W-1:0]         last_bits,
    input  logic                               first,
    input  logic                               at_start,
    input  logic [bnfa_pkg::BIT_W-1:0]         offset,
    output bnfa_pkg::scan_hit_t                hit
);
    import bnfa_pkg::*;

    // Mask of the n lowest bits, n from 0 to 8.
    function automatic logic [BITS_PER_BYTE-1:0] low_mask(input logic [BIT_W:0] n);
        logic [BITS_PER_BYTE:0] w;
        w = ({{BITS_PER_BYTE{1'b0}}, 1'b1} << n) - {{BITS_PER_BYTE{1'b0}}, 1'b1};
        return w[BITS_PER_BYTE-1:0];
    endfunction

    logic [BITS_PER_BYTE-1:0] cnt_mask;
    logic [BITS_PER_BYTE-1:0] pos_mask;
    logic [BITS_PER_BYTE-1:0] free_bits;

    always_comb begin
        // Blocks at or above the count are never candidates.
        cnt_mask = is_last ? low_mask({1'b0, last_bits} + {{BIT_W{1'b0}}, 1'b1}) : '1;
        // First visit takes bits from the pointer up; the return visit the bits below it.
        if (first) begin
            pos_mask = ~low_mask({1'b0, offset});
        end else if (at_start) begin
            pos_mask = low_mask({1'b0, offset});
        end else begin
            pos_mask = '1;
        end
        free_bits = ~data & cnt_mask & pos_mask;

        hit.found   = |free_bits;
        hit.bit_pos = '0;
        for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit.bit_pos = BIT_W'(i);
            end
        end
        hit.new_byte = data | (BITS_PER_BYTE'(1) << hit.bit_pos);
    end

endmodule

### hw/rtl/bitmap_next_fit_block_allocator.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    action, block_index, byte_index, byte_in
// m_        out        m_valid / m_ready    granted_block, byte_out, status
// cfg_      in         cfg_valid / cfg_ready cfg_data (block_count, 11 bits)
//
// One request at a time: s_ready is high only while the sequencer is idle.
// Load writes its byte on accept; free and read fetch the byte first. Allocate
// visits 1 up to ceil(count/8) + 1 map bytes (count being block_count clamped to
// 1..1024), one byte per cycle through the map's single read port and byte scan unit.
// Reset: the map reads as all free at once (per-byte valid bits, no clearing
// pass), the pointer is 0 and block_count is 1024.
// A result waiting on m_ready does not block the next request; a finished
// request holds in its last state until the output register is free.
module bitmap_next_fit_block_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [bnfa_pkg::BLK_W-1:0]          s_block_index,
    input  logic [bnfa_pkg::BYTE_IDX_W-1:0]     s_byte_index,
    input  logic [bnfa_pkg::BITS_PER_BYTE-1:0]  s_byte_in,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bnfa_pkg::BLK_W-1:0]          m_granted_block,
    output logic [bnfa_pkg::BITS_PER_BYTE-1:0]  m_byte_out,
    output logic [1:0]                          m_status,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bnfa_pkg::COUNT_W-1:0]        cfg_data
);
    import bnfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_READ,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       block_count_reg, block_count_next;
    logic [BLK_W-1:0]         next_ptr_reg, next_ptr_next;
    logic [BLK_W-1:0]         blk_reg, blk_next;
    logic [BYTE_IDX_W-1:0]    cur_reg, cur_next;
    logic [BYTE_IDX_W-1:0]    start_byte_reg, start_byte_next;
    logic [BIT_W-1:0]         offset_reg, offset_next;
    logic                     first_reg, first_next;
    logic [BLK_W-1:0]         res_granted_reg, res_granted_next;
    logic [BITS_PER_BYTE-1:0] res_byte_reg, res_byte_next;
    status_t                  res_status_reg, res_status_next;
    logic                     m_valid_reg, m_valid_next;
    logic [BLK_W-1:0]         m_granted_reg, m_granted_next;
    logic [BITS_PER_BYTE-1:0] m_byte_reg, m_byte_next;
    status_t                  m_status_reg, m_status_next;

    logic [COUNT_W-1:0]       eff_count;
    logic [COUNT_W-1:0]       eff_m1;
    logic [BYTE_IDX_W-1:0]    last_byte;
    logic [BIT_W-1:0]         last_bits;
    logic [BLK_W-1:0]         start_ptr;
    logic [BYTE_IDX_W-1:0]    scan_next_byte;
    logic                     at_start;
    logic                     s_fire;
    logic                     out_free;

    map_wr_t                  map_wr;
    logic [BYTE_IDX_W-1:0]    map_rd_addr;
    logic [BITS_PER_BYTE-1:0] map_rd_data;
    scan_hit_t                hit;
    logic [BITS_PER_BYTE-1:0] free_bit_mask;

    // Clamp the configured count to 1..MAX_BLOCKS.
    always_comb begin
        if (block_count_reg == '0) begin
            eff_count = COUNT_W'(1);
        end else if (block_count_reg > COUNT_W'(MAX_BLOCKS)) begin
            eff_count = COUNT_W'(MAX_BLOCKS);
        end else begin
            eff_count = block_count_reg;
        end
    end

    assign eff_m1    = eff_count - COUNT_W'(1);
    assign last_byte = eff_m1[BLK_W-1:BIT_W];
    assign last_bits = eff_m1[BIT_W-1:0];

    // Restart from block 0 when the pointer fell outside a lowered count.
    assign start_ptr = ({1'b0, next_ptr_reg} < eff_count) ? next_ptr_reg : '0;

    assign scan_next_byte = (cur_reg == last_byte) ? '0 : cur_reg + BYTE_IDX_W'(1);
    assign at_start       = (cur_reg == start_byte_reg);

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign free_bit_mask = BITS_PER_BYTE'(1) << blk_reg[BIT_W-1:0];

    bnfa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (map_wr),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    bnfa_byte_scan u_scan (
        .data      (map_rd_data),
        .is_last   (cur_reg == last_byte),
        .last_bits (last_bits),
        .first     (first_reg),
        .at_start  (at_start),
        .offset    (offset_reg),
        .hit       (hit)
    );

    // Map read address: issue the first byte on accept, then prefetch the
    // next byte of the scan while the current one is examined.
    always_comb begin
        unique case (state_reg)
            S_IDLE: begin
                case (s_action)
                    ACT_ALLOC: map_rd_addr = start_ptr[BLK_W-1:BIT_W];
                    ACT_FREE:  map_rd_addr = s_block_index[BLK_W-1:BIT_W];
                    default:   map_rd_addr = s_byte_index;
                endcase
            end
            S_SCAN:  map_rd_addr = scan_next_byte;
            default: map_rd_addr = cur_reg;
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        block_count_next = block_count_reg;
        next_ptr_next    = next_ptr_reg;
        blk_next         = blk_reg;
        cur_next         = cur_reg;
        start_byte_next  = start_byte_reg;
        offset_next      = offset_reg;
        first_next       = first_reg;
        res_granted_next = res_granted_reg;
        res_byte_next    = res_byte_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_granted_next   = m_granted_reg;
        m_byte_next      = m_byte_reg;
        m_status_next    = m_status_reg;
        map_wr.en        = 1'b0;
        map_wr.addr      = cur_reg;
        map_wr.data      = hit.new_byte;

        if (cfg_valid && cfg_ready) begin
            block_count_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_granted_next = '0;
                    res_byte_next    = '0;
                    res_status_next  = ST_OK;
                    blk_next         = s_block_index;
                    cur_next         = map_rd_addr;
                    case (s_action)
                        ACT_ALLOC: begin
                            start_byte_next = start_ptr[BLK_W-1:BIT_W];
                            offset_next     = start_ptr[BIT_W-1:0];
                            first_next      = 1'b1;
                            state_next      = S_SCAN;
                        end
                        ACT_FREE: begin
                            if ({1'b0, s_block_index} >= eff_count) begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_FREE;
                            end
                        end
                        ACT_LOAD: begin
                            // A 7-bit byte index always lands inside the map.
                            map_wr.en     = 1'b1;
                            map_wr.addr   = s_byte_index;
                            map_wr.data   = s_byte_in;
                            next_ptr_next = '0;
                            state_next    = S_DONE;
                        end
                        default: begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit.found) begin
                    map_wr.en        = 1'b1;
                    res_granted_next = {cur_reg, hit.bit_pos};
                    next_ptr_next    = {cur_reg, hit.bit_pos};
                    state_next       = S_DONE;
                end else if (!first_reg && at_start) begin
                    // Back at the start byte with nothing free below the pointer.
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    cur_next   = scan_next_byte;
                    first_next = 1'b0;
                end
            end
            S_FREE: begin
                if ((map_rd_data & free_bit_mask) == '0) begin
                    res_status_next = ST_ALREADY_FREE;
                end else begin
                    map_wr.en   = 1'b1;
                    map_wr.addr = blk_reg[BLK_W-1:BIT_W];
                    map_wr.data = map_rd_data & ~free_bit_mask;
                end
                state_next = S_DONE;
            end
            S_READ: begin
                res_byte_next = map_rd_data;
                state_next    = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_byte_next    = res_byte_reg;
                    m_status_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            block_count_reg <= COUNT_RESET;
            next_ptr_reg    <= '0;
            first_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            next_ptr_reg    <= next_ptr_next;
            first_reg       <= first_next;
            m_valid_reg     <= m_valid_next;
        end
        blk_reg         <= blk_next;
        cur_reg         <= cur_next;
        start_byte_reg  <= start_byte_next;
        offset_reg      <= offset_next;
        res_granted_reg <= res_granted_next;
        res_byte_reg    <= res_byte_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_byte_reg      <= m_byte_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_block = m_granted_reg;
    assign m_byte_out      = m_byte_reg;
    assign m_status        = m_status_reg;

`ifndef ASSERT_OFF
    // The scan never visits a byte past the last counted one.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cur_reg <= last_byte))
        else $error("scan byte beyond block count");

    // A new result appears only out of the final sequencer state.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // One request at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("accepted a request while busy");

    // A full map never reports a granted block.
    a_full_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_FULL)) |-> (m_granted_reg == '0))
        else $error("full status with nonzero grant");
`endif

endmodule
